FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl/core modules
// expects clk and an active-low rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tcm_pkg.sv
// types, constants and helper functions of the transform composer
// no dependencies; used by tcm_rot, trs_compose_matrix and the testbench
`timescale 1ns / 1ps

package tcm_pkg;

  localparam int QW       = 16;   // quaternion component, q1.14
  localparam int SW       = 16;   // scale component, q8.8
  localparam int PW       = 32;   // position and matrix entry, q16.16
  localparam int PRODW    = 32;   // quaternion product, q2.28
  localparam int RW       = 34;   // rotation entry, q.28 with headroom
  localparam int MULW     = RW + SW;  // scaled entry, q.36
  localparam int FRAC_SHR = 20;   // q.36 down to q16.16
  localparam int IN_W     = 4 * QW + 3 * SW + 3 * PW;
  localparam int OUT_W    = 12 * PW;

  localparam logic signed [RW-1:0] ONE_Q28 = RW'(1) <<< 28;

  typedef logic signed [RW-1:0] rval_t;

  // quaternion products, q2.28
  typedef struct packed {
    logic signed [PRODW-1:0] xx;
    logic signed [PRODW-1:0] yy;
    logic signed [PRODW-1:0] zz;
    logic signed [PRODW-1:0] xy;
    logic signed [PRODW-1:0] zw;
    logic signed [PRODW-1:0] zx;
    logic signed [PRODW-1:0] yw;
    logic signed [PRODW-1:0] yz;
    logic signed [PRODW-1:0] xw;
  } prod_t;

  // row-major rotation entries, index i*3+j
  typedef logic [8:0][RW-1:0] rot_t;

  // fields that ride along with the rotation math
  typedef struct packed {
    logic [2:0][PW-1:0] pos;    // x at index 0
    logic [2:0][SW-1:0] scale;  // x at index 0
  } carry_t;

  typedef struct packed {
    carry_t             carry;
    logic [3:0][QW-1:0] quat;   // x, y, z, w from index 0
  } item_t;

  function automatic rval_t twice_sum(input logic signed [PRODW-1:0] a,
                                      input logic signed [PRODW-1:0] b);
    rval_t s;
    s = RW'(a) + RW'(b);
    return s <<< 1;
  endfunction

  function automatic rval_t twice_diff(input logic signed [PRODW-1:0] a,
                                       input logic signed [PRODW-1:0] b);
    rval_t s;
    s = RW'(a) - RW'(b);
    return s <<< 1;
  endfunction

  function automatic rval_t one_minus(input logic signed [PRODW-1:0] a,
                                      input logic signed [PRODW-1:0] b);
    rval_t s;
    s = RW'(a) + RW'(b);
    return ONE_Q28 - (s <<< 1);
  endfunction

endpackage

FILE: rtl/core/tcm_rot.sv
// two-stage rotation matrix builder: quaternion products, then entries
// depends on tcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcm_rot (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcm_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output tcm_pkg::rot_t  out_rot,
  output tcm_pkg::carry_t out_carry
);
  import tcm_pkg::*;

  logic signed [QW-1:0] qx, qy, qz, qw;

  // stage a: products
  logic   va_r;
  prod_t  prod_r, prod_nxt;
  carry_t carry_a_r;

  // stage b: rotation entries
  logic   vb_r;
  rot_t   rot_r, rot_nxt;
  carry_t carry_b_r;

  logic ready_a, ready_b;

  assign ready_b  = !vb_r || out_ready;
  assign ready_a  = !va_r || ready_b;
  assign in_ready = ready_a;

  assign qx = $signed(in_item.quat[0]);
  assign qy = $signed(in_item.quat[1]);
  assign qz = $signed(in_item.quat[2]);
  assign qw = $signed(in_item.quat[3]);

  always_comb begin
    prod_nxt.xx = qx * qx;
    prod_nxt.yy = qy * qy;
    prod_nxt.zz = qz * qz;
    prod_nxt.xy = qx * qy;
    prod_nxt.zw = qz * qw;
    prod_nxt.zx = qz * qx;
    prod_nxt.yw = qy * qw;
    prod_nxt.yz = qy * qz;
    prod_nxt.xw = qx * qw;
  end

  always_comb begin
    rot_nxt[0] = one_minus(prod_r.yy, prod_r.zz);
    rot_nxt[1] = twice_sum(prod_r.xy, prod_r.zw);
    rot_nxt[2] = twice_diff(prod_r.zx, prod_r.yw);
    rot_nxt[3] = twice_diff(prod_r.xy, prod_r.zw);
    rot_nxt[4] = one_minus(prod_r.zz, prod_r.xx);
    rot_nxt[5] = twice_sum(prod_r.yz, prod_r.xw);
    rot_nxt[6] = twice_sum(prod_r.zx, prod_r.yw);
    rot_nxt[7] = twice_diff(prod_r.yz, prod_r.xw);
    rot_nxt[8] = one_minus(prod_r.yy, prod_r.xx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_valid;
      if (ready_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      prod_r    <= prod_nxt;
      carry_a_r <= in_item.carry;
    end
    if (ready_b && va_r) begin
      rot_r     <= rot_nxt;
      carry_b_r <= carry_a_r;
    end
  end

  assign out_valid = vb_r;
  assign out_rot   = rot_r;
  assign out_carry = carry_b_r;

  `ASSERT_NEXT(a_rot_advance, va_r && ready_b, vb_r, "rot: product stage lost its item")
  `ASSERT_PROP(a_rot_full, !in_ready |-> (va_r && vb_r && !out_ready),
               "rot: input stalled with a free stage")

endmodule

FILE: rtl/core/trs_compose_matrix.sv
// top level of the scale-rotate-translate matrix composer
// depends on tcm_pkg, tcm_rot and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// usage
//   in_*  : one transfer per object: quaternion (q1.14), per-axis scale (q8.8)
//           and position (q16.16); see the in_tdata comment for the layout
//   out_* : one transfer per object: the nine scaled rotation entries and
//           the translation column, all q16.16; the constant 0/1 entries of
//           the 4x4 matrix are not sent
//   throughput : one object per cycle unless stalled; four stages (quaternion
//                products, rotation entries, 34x16 scale multiply, floor shift
//                into the output register), each stage with its own valid bit
//   rounding   : scaled entries drop 20 fraction bits by arithmetic shift
//                (toward minus infinity), no saturation
//   stalls     : each stage holds its item while the next one is full, so a
//                stalled receiver backs the pipe up stage by stage; in_tready
//                falls only when all four stages are occupied and bubbles
//                are squeezed out on the way
//   reset      : synchronous rst_n empties all stages; the block is ready
//                for input in the first cycle after reset
//
module trs_compose_matrix (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z,
  // pos_x, pos_y, pos_z
  input  logic [tcm_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // e00, e01, e02, e10, e11, e12, e20, e21, e22, trans_x, trans_y, trans_z
  output logic [tcm_pkg::OUT_W-1:0] out_tdata
);
  import tcm_pkg::*;

  item_t  in_item;

  // rotation pipe handshake and payload
  logic   rot_valid, rot_ready;
  rot_t   rot;
  carry_t rot_carry;

  // stage c: rotation entry times scale, q.36
  logic                    vc_r;
  logic signed [MULW-1:0]  mul_r   [9];
  logic signed [MULW-1:0]  mul_nxt [9];
  logic [2:0][PW-1:0]      pos_c_r;

  // stage d: output register, q16.16
  logic                    vd_r;
  logic [8:0][PW-1:0]      ent_r, ent_nxt;
  logic [2:0][PW-1:0]      pos_d_r;

  logic ready_c, ready_d;

  // unpack the input transfer, quaternion in the low bits
  assign in_item = item_t'(in_tdata);

  tcm_rot u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rot   (rot),
    .out_carry (rot_carry)
  );

  // each stage moves when empty or when its successor moves
  assign ready_d   = !vd_r || out_tready;
  assign ready_c   = !vc_r || ready_d;
  assign rot_ready = ready_c;

  // column j of the matrix takes scale component j
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      mul_nxt[k] = MULW'($signed(rot[k])) * MULW'($signed(rot_carry.scale[k % 3]));
    end
  end

  // floor shift; the low 32 bits of the shifted value are the entry
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ent_nxt[k] = PW'(mul_r[k] >>> FRAC_SHR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (ready_c) vc_r <= rot_valid;
      if (ready_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_c && rot_valid) begin
      mul_r   <= mul_nxt;
      pos_c_r <= rot_carry.pos;
    end
    if (ready_d && vc_r) begin
      ent_r   <= ent_nxt;
      pos_d_r <= pos_c_r;
    end
  end

  assign out_tvalid = vd_r;
  assign out_tdata  = {pos_d_r, ent_r};

  `ASSERT_NEXT(a_out_fill, vc_r && ready_d, out_tvalid, "top: scaled entries not delivered")
  `ASSERT_PROP(a_in_backed_up, !in_tready |-> (rot_valid && vc_r && vd_r && !out_tready),
               "top: input stalled while the pipe has a free stage")

endmodule

FILE: bench/tb_trs_compose_matrix.sv
// testbench for trs_compose_matrix: streams quaternion, scale and position
// transfers and checks each 4x4 matrix result against an in-bench predictor
// depends on tcm_pkg (port widths) and the trs_compose_matrix rtl
`timescale 1ns / 1ps

module tb_trs_compose_matrix;
  import tcm_pkg::*;

  localparam int HOLD_LEN    = 300;     // long receiver hold-off, in cycles
  localparam int CYCLE_LIMIT = 200000;  // generous bound on the whole run
  localparam int MAX_ERRORS  = 40;      // keep the log readable on a bad design
  localparam int DRAIN_CYCLES = 8;      // idle wait after the last result, in cycles

  // one input transfer; first member lands in the top bits of in_tdata
  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [15:0] scale_z;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
  } xform_t;

  // result entries: e00..e22 at indexes 0..8, then trans_x, trans_y, trans_z
  typedef logic [11:0][31:0] matrix_t;

  localparam string ENTRY_NAME [12] = '{"e00", "e01", "e02", "e10", "e11", "e12",
                                        "e20", "e21", "e22",
                                        "trans_x", "trans_y", "trans_z"};

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  matrix_t matrix_q [$];   // predicted matrices, oldest first
  bit      failed    = 1'b0;
  int      err_count = 0;
  int      cycles    = 0;

  // idling percentages of the current phase
  int send_idle  = 0;
  int recv_stall = 0;

  // long hold-off handshake between the test and the receiver process
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  matrix_t want_m, got_m;

  trs_compose_matrix dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // run-time bound: a hung pipe ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // q.28 rotation entry times q8.8 scale, floored down to q16.16
  function automatic logic [31:0] scaled_entry(input longint rot,
                                               input logic signed [15:0] s);
    longint p;
    p = rot * longint'(s);
    return 32'(p >>> 20);
  endfunction

  // full matrix of one transform; products exact in q2.28, no saturation
  function automatic matrix_t compose_matrix(input xform_t t);
    longint  qx, qy, qz, qw, one_q28;
    longint  xx, yy, zz, xy, zw, zx, yw, yz, xw;
    matrix_t m;
    qx = longint'(t.quat_x);
    qy = longint'(t.quat_y);
    qz = longint'(t.quat_z);
    qw = longint'(t.quat_w);
    one_q28 = 64'sd1 <<< 28;
    xx = qx * qx;  yy = qy * qy;  zz = qz * qz;
    xy = qx * qy;  zw = qz * qw;  zx = qz * qx;
    yw = qy * qw;  yz = qy * qz;  xw = qx * qw;
    m[0]  = scaled_entry(one_q28 - 2 * (yy + zz), t.scale_x);
    m[1]  = scaled_entry(2 * (xy + zw),           t.scale_y);
    m[2]  = scaled_entry(2 * (zx - yw),           t.scale_z);
    m[3]  = scaled_entry(2 * (xy - zw),           t.scale_x);
    m[4]  = scaled_entry(one_q28 - 2 * (zz + xx), t.scale_y);
    m[5]  = scaled_entry(2 * (yz + xw),           t.scale_z);
    m[6]  = scaled_entry(2 * (zx + yw),           t.scale_x);
    m[7]  = scaled_entry(2 * (yz - xw),           t.scale_y);
    m[8]  = scaled_entry(one_q28 - 2 * (yy + xx), t.scale_z);
    m[9]  = t.pos_x;
    m[10] = t.pos_y;
    m[11] = t.pos_z;
    return m;
  endfunction

  function automatic xform_t make_xform(input int qx, qy, qz, qw, sx, sy, sz,
                                        input logic [31:0] px, py, pz);
    xform_t t;
    t.quat_x  = 16'(qx);
    t.quat_y  = 16'(qy);
    t.quat_z  = 16'(qz);
    t.quat_w  = 16'(qw);
    t.scale_x = 16'(sx);
    t.scale_y = 16'(sy);
    t.scale_z = 16'(sz);
    t.pos_x   = px;
    t.pos_y   = py;
    t.pos_z   = pz;
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // offer one transform and wait for its transfer; valid stays high after
  // the transfer so back-to-back items need no extra edge
  task automatic send_transform(input xform_t t);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    // in_tready read here still holds its value from before the edge
    while (!in_tready) @(posedge clk);
    matrix_q.push_back(compose_matrix(t));
  endtask

  // mostly in-range quaternions, some arbitrary 16-bit patterns
  function automatic int rand_quat();
    if ($urandom_range(9) == 0)
      return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(32768)) - 16384;
  endfunction

  // scale: full range, or small values (-2.0 to 2.0 in q8.8) now and then
  function automatic int rand_scale();
    if ($urandom_range(3) == 0)
      return int'($urandom_range(1024)) - 512;
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic xform_t rand_xform();
    return make_xform(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                      rand_scale(), rand_scale(), rand_scale(),
                      $urandom(), $urandom(), $urandom());
  endfunction

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // receiver: random stalls, or a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        failed = 1'b1;
        if (err_count < MAX_ERRORS) $error("result transfer with no matrix expected");
        err_count++;
      end else begin
        want_m = matrix_q.pop_front();
        got_m  = out_tdata;
        for (int k = 0; k < 12; k++) begin
          if (got_m[k] !== want_m[k]) begin
            failed = 1'b1;
            if (err_count < MAX_ERRORS)
              $error("%s expected %h actual %h", ENTRY_NAME[k], want_m[k], got_m[k]);
            err_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // field extremes, exact rotations, non-unit and out of range quaternions
  task automatic test_directed();
    send_idle  = 0;
    recv_stall = 0;
    // identity, unit scale, zero position
    send_transform(make_xform(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0));
    // identity through negative w
    send_transform(make_xform(0, 0, 0, -16384, 256, 256, 256, 32'h0001_0000,
                              32'hFFFF_0000, 32'h0000_8000));
    // half turns about each axis
    send_transform(make_xform(16384, 0, 0, 0, 512, 256, 128, 1, 2, 3));
    send_transform(make_xform(0, 16384, 0, 0, 256, 512, 768, 0, 0, 0));
    send_transform(make_xform(0, 0, 16384, 0, -256, 256, -256, 0, 0, 0));
    // quarter turn about z, not exactly unit after rounding
    send_transform(make_xform(0, 0, 11585, 11585, 256, 256, 256, 0, 0, 0));
    // non-unit quaternions
    send_transform(make_xform(16384, 16384, 16384, 16384, 256, 256, 256, 0, 0, 0));
    send_transform(make_xform(-16384, -16384, -16384, -16384, -32768, -32768, -32768,
                              32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_transform(make_xform(16384, -16384, 16384, -16384, 32767, 32767, 32767,
                              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // out of range quaternions: any 16-bit pattern uses the same formula
    send_transform(make_xform(-32768, -32768, -32768, -32768, 32767, -32768, 32767,
                              32'hFFFF_FFFF, 0, 32'h8000_0000));
    send_transform(make_xform(32767, 32767, 32767, 32767, -32768, 32767, -32768,
                              0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    send_transform(make_xform(-32768, 32767, -32768, 32767, -32768, -32768, -32768,
                              32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F));
    send_transform(make_xform(32767, -32768, 32767, -32768, 32767, 32767, 32767,
                              32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0));
    // zero quaternion and zero scale
    send_transform(make_xform(0, 0, 0, 0, 256, 256, 256, 0, 0, 0));
    send_transform(make_xform(9000, -7000, 3000, 12000, 0, 0, 0, 0, 0, 0));
    // tiny negative products must floor to -1
    send_transform(make_xform(1, 1, 0, 0, -1, -1, -1, 0, 0, 0));
    send_transform(make_xform(0, 1, 1, 0, 1, -1, 1, 0, 0, 0));
    send_transform(make_xform(1, 0, 1, -1, -1, 1, -1, 0, 0, 0));
    // smallest scale steps around an arbitrary rotation
    send_transform(make_xform(5793, 5793, 5793, 11585, 1, -1, 1,
                              32'h0000_0001, 32'hFFFF_FFFE, 32'h0001_0001));
    send_transform(make_xform(-16384, 16384, 0, 16384, 32767, -32768, 1,
                              32'h1234_5678, 32'h9ABC_DEF0, 32'h0BAD_F00D));
  endtask

  task automatic test_random_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    repeat (n) send_transform(rand_xform());
  endtask

  // receiver holds off for a long stretch while input keeps coming, so the
  // pipe fills and in_tready must drop
  task automatic test_backpressure();
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = hold_req + 1;
    repeat (60) send_transform(rand_xform());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(440, 0, 0);
    test_random_phase(440, 45, 0);
    test_random_phase(440, 0, 45);
    test_backpressure();
    test_random_phase(440, 24, 24);

    in_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && matrix_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: trs_compose_matrix.f
+incdir+rtl/core
rtl/core/tcm_pkg.sv
rtl/core/tcm_rot.sv
rtl/core/trs_compose_matrix.sv
bench/tb_trs_compose_matrix.sv
